// ===== hw/rtl/cubic_spline_evaluator_core_assert.svh =====
// Assertion macros shared by the checker of the spline evaluator.
// No dependencies.
`ifndef CUBIC_SPLINE_EVALUATOR_CORE_ASSERT_SVH
`define CUBIC_SPLINE_EVALUATOR_CORE_ASSERT_SVH
// implication checked at every rising clock edge, muted during reset
`define CSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/cse_pkg.sv =====
// Package for the cubic spline evaluator: widths, constants, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;
  localparam int MaxKnots  = 64;
  localparam int FracBits  = 16;
  localparam int IdxW      = 6;
  localparam int CountW    = 7;
  localparam int DataW     = 32;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [IdxW-1:0]         entry_index;
    logic signed [DataW-1:0] knot_position;
    logic signed [DataW-1:0] coef_const;
    logic signed [DataW-1:0] coef_linear;
    logic signed [DataW-1:0] coef_square;
    logic signed [DataW-1:0] coef_cube;
    logic signed [DataW-1:0] query_point;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] spline_value;
    logic signed [DataW-1:0] first_derivative;
    logic signed [DataW-1:0] second_derivative;
    logic [IdxW-1:0]         segment_found;
    logic                    out_of_range;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RANGE_RD, ST_RANGE_CHK, ST_SEARCH_RD, ST_SEARCH_CMP,
    ST_COEF_RD, ST_MUL, ST_ADD, ST_OUT
  } state_t;

  // Horner step select
  typedef enum logic [2:0] {
    OP_DP, OP_V1, OP_V2, OP_U1, OP_LAST
  } step_t;

  typedef struct packed {
    logic  load;       // capture input transaction
    logic  write_tab;  // write table entry
    logic  rd_first;   // read knot 0
    logic  rd_last;    // read knot n-1
    logic  chk_range;  // latch range result
    logic  init_srch;
    logic  rd_mid;
    logic  cmp_mid;
    logic  rd_coef;
    logic  mul;
    logic  add;
    step_t step;
    logic  set_oor;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic oor;
    logic srch_done;
  } sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+3:0] v);
    logic signed [DataW+3:0] mx;
    logic signed [DataW+3:0] mn;
    mx = (DataW+4)'(signed'({1'b0, {(DataW-1){1'b1}}}));
    mn = -mx - (DataW+4)'(1);
    if (v > mx) return {1'b0, {(DataW-1){1'b1}}};
    else if (v < mn) return {1'b1, {(DataW-1){1'b0}}};
    else return v[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/cse_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
// Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cse_in_if;
  import cse_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cse_out_if;
  import cse_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cubic_spline_evaluator_core.sv =====
// Top level of the cubic spline evaluator: config register, controller, datapath.
// Depends on cse_pkg, cse_stream_if, cse_ctrl, cse_datapath.
// A write transaction (mode 0) stores one knot and its segment coefficients a..d
// in the cycle after acceptance and returns nothing; the controller then returns
// to idle for the next transaction. A query transaction (mode 1) checks the point
// against the first and last knot, binary-searches the knot table (a read and a
// compare per step, one to seven steps for up to 64 knots, fewer on an exact knot
// hit), reads the segment, then runs five multiply/add passes of the single 32x33
// multiplier; the search loop and the shared multiplier set how long a query
// occupies the core. Out-of-range queries skip the search and the multiply
// passes and give zeros and the flag. The result sits in an output register, so
// the next transaction may be accepted while it waits; a following query that
// finishes before that result is taken holds until it is. Table entries are
// undefined until written. The user must write knot_count only while idle; the
// block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module cubic_spline_evaluator_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [cse_pkg::CountW-1:0] cfg_wdata,
  cse_in_if.sink                          in_ch,
  cse_out_if.source                       out_ch
);
  import cse_pkg::*;
  logic [CountW-1:0] knot_count;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) knot_count <= CountW'(2);
    else if (cfg_we) knot_count <= cfg_wdata;
  end

  cse_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .sts, .cmd
  );

  cse_datapath u_dp (
    .clk, .knot_count, .in_data (in_ch.data), .cmd, .sts,
    .out_data (out_ch.data)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/cse_ctrl.sv =====
// Controller FSM of the spline evaluator: sequences write, search, Horner steps.
// Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cse_pkg::sts_t sts,
  output cse_pkg::cmd_t      cmd
);
  import cse_pkg::*;
  state_t state, state_next;
  step_t  step, step_next;
  logic   ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= OP_DP;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      ov    <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    state_next = state;
    step_next  = step;
    ov_next    = ov && !out_ready;
    cmd        = '0;
    cmd.step   = step;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RANGE_RD;
        end
      end
      ST_RANGE_RD: begin
        if (!sts.is_query) begin
          cmd.write_tab = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.rd_first  = 1'b1;
          cmd.rd_last   = 1'b1;
          state_next    = ST_RANGE_CHK;
        end
      end
      ST_RANGE_CHK: begin
        cmd.chk_range = 1'b1;
        cmd.init_srch = 1'b1;
        state_next    = ST_SEARCH_RD;
      end
      ST_SEARCH_RD: begin
        if (sts.oor) begin
          state_next  = ST_OUT;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        cmd.cmp_mid = 1'b1;
        state_next  = sts.srch_done ? ST_COEF_RD : ST_SEARCH_RD;
      end
      ST_COEF_RD: begin
        cmd.rd_coef = 1'b1;
        step_next   = OP_DP;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (step == OP_LAST) begin
          state_next = ST_OUT;
        end else begin
          step_next  = step_t'(step + 3'd1);
          state_next = ST_MUL;
        end
      end
      ST_OUT: begin
        cmd.set_oor = sts.oor;
        if (!ov || out_ready) begin
          cmd.out_load = 1'b1;
          ov_next      = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/cse_datapath.sv =====
// Datapath: coefficient tables, binary search registers, shared multiplier.
// Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cse_datapath (
  input  wire logic                         clk,
  input  wire logic [cse_pkg::CountW-1:0]   knot_count,
  input  wire cse_pkg::in_item_t            in_data,
  input  wire cse_pkg::cmd_t                cmd,
  output cse_pkg::sts_t                     sts,
  output cse_pkg::out_item_t                out_data
);
  import cse_pkg::*;
  localparam int W = DataW;
  localparam int PW = 2*W + 2;

  logic [4*W-1:0]  coef_mem [MaxKnots];
  logic [W-1:0]    knot_mem [MaxKnots];
  in_item_t        item;
  logic [W-1:0]    kd0, kd1;
  logic [4*W-1:0]  cd;
  logic [IdxW:0]   lo, hi, mid, nsat;
  logic [IdxW-1:0] seg, ka;
  logic            oor, done;
  logic signed [W:0]    dx;
  logic signed [W-1:0]  acc, ca, cb, cc, cd_d;
  logic signed [PW-1:0] prod;
  logic signed [W+3:0]  sh, sum;
  logic signed [W-1:0]  v1, u1, w1;
  logic signed [W-1:0]  mop;

  assign nsat = (knot_count < CountW'(2)) ? (IdxW+1)'(2) :
                (knot_count > CountW'(MaxKnots)) ? (IdxW+1)'(MaxKnots) : knot_count;

  // one shared knot read port: knot 0, search midpoint, then the chosen segment
  assign ka = cmd.rd_mid ? mid[IdxW-1:0] : (cmd.rd_coef ? seg : '0);

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.write_tab) begin
      knot_mem[item.entry_index] <= item.knot_position;
      coef_mem[item.entry_index] <= {item.coef_const, item.coef_linear,
                                     item.coef_square, item.coef_cube};
    end
    if (cmd.rd_first || cmd.rd_mid || cmd.rd_coef) kd0 <= knot_mem[ka];
    if (cmd.rd_last)  kd1 <= knot_mem[IdxW'(nsat - (IdxW+1)'(1))];
    if (cmd.rd_coef)  cd  <= coef_mem[seg];
  end

  assign mid = (lo + hi) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.chk_range)
      oor <= ($signed(item.query_point) < $signed(kd0)) ||
             ($signed(item.query_point) > $signed(kd1));
    if (cmd.init_srch) begin
      lo   <= '0;
      hi   <= nsat;
      done <= 1'b0;
    end
    if (cmd.cmp_mid) begin
      if (item.query_point == kd0 || hi - lo <= (IdxW+1)'(1)) begin
        done <= 1'b1;
        seg  <= (mid > nsat - (IdxW+1)'(2)) ? IdxW'(nsat - (IdxW+1)'(2))
                                            : mid[IdxW-1:0];
      end else if ($signed(item.query_point) > $signed(kd0)) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
  end

  // kd0 holds the segment's knot from the coefficient read onwards
  assign dx = $signed({item.query_point[W-1], item.query_point}) -
              $signed({kd0[W-1], kd0});

  assign ca = cd[4*W-1:3*W];
  assign cb = cd[3*W-1:2*W];
  assign cc = cd[2*W-1:W];
  assign cd_d = cd[W-1:0];

  always_comb begin
    unique case (cmd.step)
      OP_DP:   mop = cd_d;
      OP_V1:   mop = v1;
      OP_V2:   mop = acc;
      OP_U1:   mop = u1;
      default: mop = acc;
    endcase
  end

  // floor shift is an arithmetic right shift; clamping to [-2^32, 2^32-1] keeps 6*sh + 2c
  // inside sh's width and never changes a saturated result
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= PW'(mop) * PW'(dx);
  end

  always_comb begin
    logic signed [PW-1:0] s;
    s = prod >>> FracBits;
    if (s > PW'(64'sh0000_0000_FFFF_FFFF))       sh = (W+4)'(36'sh0_FFFF_FFFF);
    else if (s < -PW'(64'sh0000_0001_0000_0000)) sh = -(W+4)'(36'sh1_0000_0000);
    else sh = s[W+3:0];
  end

  always_comb begin
    unique case (cmd.step)
      OP_DP:   sum = sh + (W+4)'(cc);
      OP_V1:   sum = sh + (W+4)'(cb);
      OP_V2:   sum = sh + (W+4)'(ca);
      OP_U1:   sum = sh + (W+4)'(cb);
      default: sum = sh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      unique case (cmd.step)
        OP_DP: begin
          v1 <= sat32(sum);
          u1 <= sat32(3 * sh + 2 * (W+4)'(cc));
          w1 <= sat32(6 * sh + 2 * (W+4)'(cc));
        end
        OP_V1:   acc <= sat32(sum);
        OP_V2:   acc <= sat32(sum);
        OP_U1:   u1  <= sat32(sum);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data.spline_value      <= cmd.set_oor ? '0 : acc;
      out_data.first_derivative  <= cmd.set_oor ? '0 : u1;
      out_data.second_derivative <= cmd.set_oor ? '0 : w1;
      out_data.segment_found     <= cmd.set_oor ? '0 : seg;
      out_data.out_of_range      <= cmd.set_oor;
    end
  end

  assign sts.is_query  = (item.mode == MODE_QUERY);
  assign sts.oor       = oor;
  assign sts.srch_done = done || (cmd.cmp_mid &&
                         (item.query_point == kd0 || hi - lo <= (IdxW+1)'(1)));
endmodule
`default_nettype wire

// ===== hw/rtl/cse_checker.sv =====
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on cse_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_spline_evaluator_core_assert.svh"
module cse_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic oor,
  input wire logic [cse_pkg::IdxW-1:0] seg
);
  `CSE_ASSERT_NXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CSE_ASSERT_IMP(a_oor_seg, clk, rst, out_valid && oor, seg == '0, "oor with segment")
  `CSE_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "accepted twice")
endmodule
bind cubic_spline_evaluator_core cse_checker u_chk (
  .clk, .rst, .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .oor (out_ch.data.out_of_range), .seg (out_ch.data.segment_found)
);
`default_nettype wire
